// ===== rtl/bsad_pkg.sv =====
// ----------------------------------------------------------------------------
// bsad_pkg
// shared widths, defaults and register codes for the block sad engine
// ----------------------------------------------------------------------------
package bsad_pkg;

  // sample and row geometry
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned ROW_SAMPLES = 16;
  localparam int unsigned FIELD_W     = 64;

  // reduction tree: groups of four lanes, then the group partials
  localparam int unsigned GRP_LANES = 4;
  localparam int unsigned PART_W    = 18;
  localparam int unsigned TOTAL_W   = 20;

  // configuration
  localparam int unsigned CFG_W      = 5;
  localparam logic [4:0]  ROWS_RESET = 5'd16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // register index codes (paddr[2])
  localparam logic REG_BLOCK_ROWS = 1'b0;

  // defaults for the top level parameters
  localparam int unsigned DEF_LANES    = 16;
  localparam int unsigned DEF_MAX_ROWS = 16;

  // queue depths
  localparam int unsigned ROW_Q_DEPTH = 4;
  localparam int unsigned RES_Q_DEPTH = 4;

endpackage

// ===== rtl/bsad_fifo.sv =====
// ----------------------------------------------------------------------------
// bsad_fifo
// small synchronous queue in flip-flops, head visible while not empty
// ----------------------------------------------------------------------------
module bsad_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("fifo written while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("fifo read while empty");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fifo count beyond depth");
`endif

endmodule

// ===== rtl/bsad_front.sv =====
// ----------------------------------------------------------------------------
// bsad_front
// per-lane saturating absolute difference and block row counting
// ----------------------------------------------------------------------------
module bsad_front import bsad_pkg::*; #(
  parameter int unsigned LANES    = DEF_LANES,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [ROW_SAMPLES*SAMPLE_W-1:0]   cur_row_i,
  input  logic [ROW_SAMPLES*SAMPLE_W-1:0]   ref_row_i,
  input  logic [CFG_W-1:0]                  block_rows_i,
  output logic [LANES*SAMPLE_W-1:0]         diff_o,
  output logic                              last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  logic [CNT_W-1:0] row_cnt_q, row_cnt_d;
  logic [CMP_W-1:0] rows_eff;
  logic [CMP_W-1:0] cnt_next;

  // saturate cur - ref to 16 bits, then magnitude; 0x8000 stays 0x8000
  function automatic logic [SAMPLE_W-1:0] abs_sat_diff(input logic [SAMPLE_W-1:0] a,
                                                        input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0]   d;
    logic [SAMPLE_W-1:0] s;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    if (d[SAMPLE_W] != d[SAMPLE_W-1]) begin
      s = d[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      s = d[SAMPLE_W-1:0];
    end
    return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      diff_o[l*SAMPLE_W +: SAMPLE_W] = abs_sat_diff(cur_row_i[l*SAMPLE_W +: SAMPLE_W],
                                                    ref_row_i[l*SAMPLE_W +: SAMPLE_W]);
    end
  end

  // height zero acts as one, height above the maximum acts as the maximum
  always_comb begin
    if (block_rows_i == '0) begin
      rows_eff = CMP_W'(1);
    end else if (CMP_W'(block_rows_i) > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = CMP_W'(block_rows_i);
    end
  end

  assign cnt_next = CMP_W'(row_cnt_q) + 1'b1;
  assign last_o   = (cnt_next >= rows_eff);

  always_comb begin
    row_cnt_d = row_cnt_q;
    if (accept_i) begin
      row_cnt_d = last_o ? '0 : cnt_next[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else begin
      row_cnt_q <= row_cnt_d;
    end
  end

endmodule

// ===== rtl/bsad_back.sv =====
// ----------------------------------------------------------------------------
// bsad_back
// lane accumulators, registered reduction tree and result queue
// ----------------------------------------------------------------------------
module bsad_back import bsad_pkg::*; #(
  parameter int unsigned LANES = DEF_LANES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        row_valid_i,
  input  logic [LANES*SAMPLE_W-1:0]   row_diff_i,
  input  logic                        row_last_i,
  output logic                        row_pop_o,
  input  logic                        res_pop_i,
  output logic                        res_empty_o,
  output logic signed [TOTAL_W-1:0]   res_total_o
);

  localparam int unsigned NGRP  = (LANES + GRP_LANES - 1) / GRP_LANES;
  localparam int unsigned RCNT_W = $clog2(RES_Q_DEPTH + 1);
  localparam int unsigned OCC_W  = RCNT_W + 1;

  logic [LANES-1:0][SAMPLE_W-1:0] lane_sums_q, lane_sums_d;
  logic [LANES-1:0][SAMPLE_W-1:0] sums_new;
  logic [LANES-1:0][SAMPLE_W-1:0] fin_lanes_q;
  logic                           fin_valid_q;
  logic [NGRP-1:0][PART_W-1:0]    part_q, part_d;
  logic                           part_valid_q;
  logic [TOTAL_W-1:0]             total;
  logic [RCNT_W-1:0]              res_count;
  logic                           res_full;
  logic [OCC_W-1:0]               occupancy;
  logic                           take;

  // results in the tree plus those queued must leave a slot for a new total
  assign occupancy = OCC_W'(res_count) + OCC_W'(fin_valid_q) + OCC_W'(part_valid_q);
  assign take      = row_valid_i && (!row_last_i || (occupancy < OCC_W'(RES_Q_DEPTH)));
  assign row_pop_o = take;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sums_new[l] = lane_sums_q[l] + row_diff_i[l*SAMPLE_W +: SAMPLE_W];
    end
  end

  always_comb begin
    lane_sums_d = lane_sums_q;
    if (take) begin
      lane_sums_d = row_last_i ? '0 : sums_new;
    end
  end

  // first tree level: sign-extended lane sums in groups of four
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GRP_LANES; k++) begin
        if (g * GRP_LANES + k < LANES) begin
          part_d[g] = part_d[g]
                    + PART_W'($signed(fin_lanes_q[(g*GRP_LANES+k) % LANES]));
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + TOTAL_W'($signed(part_q[g]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_sums_q  <= '0;
      fin_valid_q  <= 1'b0;
      part_valid_q <= 1'b0;
    end else begin
      lane_sums_q  <= lane_sums_d;
      fin_valid_q  <= take && row_last_i;
      part_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && row_last_i) begin
      fin_lanes_q <= sums_new;
    end
    if (fin_valid_q) begin
      part_q <= part_d;
    end
  end

  bsad_fifo #(
    .WIDTH (TOTAL_W),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (part_valid_q),
    .wdata_i (total),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .rdata_o (res_total_o),
    .empty_o (res_empty_o),
    .count_o (res_count)
  );

`ifndef SYNTH
  a_res_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    part_valid_q |-> (!res_full || res_pop_i))
    else $error("total reached a full result queue");
  a_clear_after_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && row_last_i) |=> (lane_sums_q == '0))
    else $error("lane sums not cleared after last row");
`endif

endmodule

// ===== rtl/block_sad_int16.sv =====
// ----------------------------------------------------------------------------
// block_sad_int16
// sum of absolute differences over blocks of signed 16-bit samples
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  row in    | push / full            | cur_lanes_*_i, ref_lanes_*_i (16 lanes)
//  total out | pop / empty            | sad_total_o (20 bit signed)
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata (block_rows)
//
//  one row per cycle sustained while full stays low; a row lands in the row queue on
//  the cycle it is accepted, and the accumulators take it from the head of the row
//  queue once the back side can take it. after its last row is taken, a total
//  passes through the registered final lane sums and group sums, then the final
//  add is written into the result queue (accumulate, group sums, final add)
//  full rises only when the 4-entry row queue is full, which happens only
//  when the result queue and reduction tree hold four totals not yet popped
//  reset clears accumulators, row count, queues; block_rows resets to 16
//
// ----------------------------------------------------------------------------
module block_sad_int16 import bsad_pkg::*; #(
  parameter int unsigned LANES    = DEF_LANES,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // row input side
  input  logic                        push,
  output logic                        full,
  input  logic [FIELD_W-1:0]          cur_lanes_0_3_i,
  input  logic [FIELD_W-1:0]          cur_lanes_4_7_i,
  input  logic [FIELD_W-1:0]          cur_lanes_8_11_i,
  input  logic [FIELD_W-1:0]          cur_lanes_12_15_i,
  input  logic [FIELD_W-1:0]          ref_lanes_0_3_i,
  input  logic [FIELD_W-1:0]          ref_lanes_4_7_i,
  input  logic [FIELD_W-1:0]          ref_lanes_8_11_i,
  input  logic [FIELD_W-1:0]          ref_lanes_12_15_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic signed [TOTAL_W-1:0]   sad_total_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_W-1:0]       paddr,
  input  logic [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready
);

  localparam int unsigned ENTRY_W = LANES * SAMPLE_W + 1;

  // configuration register
  logic [CFG_W-1:0] block_rows_q, block_rows_d;
  logic             reg_idx;
  logic             cfg_write;

  // row path
  logic                              in_accept;
  logic [ROW_SAMPLES*SAMPLE_W-1:0]   cur_row;
  logic [ROW_SAMPLES*SAMPLE_W-1:0]   ref_row;
  logic [LANES*SAMPLE_W-1:0]         front_diff;
  logic                              front_last;
  logic [ENTRY_W-1:0]                row_q_wdata;
  logic [ENTRY_W-1:0]                row_q_rdata;
  logic                              row_q_empty;
  logic                              row_q_pop;
  logic [$clog2(ROW_Q_DEPTH+1)-1:0]  row_q_count;

  // ---------------------------------------------------------------------------
  // register port: always ready, one register at index 0 (paddr[2])
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    block_rows_d = block_rows_q;
    if (cfg_write) begin
      case (reg_idx)
        REG_BLOCK_ROWS: block_rows_d = pwdata[CFG_W-1:0];
        default:        block_rows_d = block_rows_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLOCK_ROWS: prdata = APB_DATA_W'(block_rows_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_rows_q <= ROWS_RESET;
    end else begin
      block_rows_q <= block_rows_d;
    end
  end

  // ---------------------------------------------------------------------------
  // front: lane differences and block boundary detection at accept time
  // ---------------------------------------------------------------------------
  assign in_accept = push && !full;

  // lane 0 in the low bits of the lowest field
  assign cur_row = {cur_lanes_12_15_i, cur_lanes_8_11_i, cur_lanes_4_7_i, cur_lanes_0_3_i};
  assign ref_row = {ref_lanes_12_15_i, ref_lanes_8_11_i, ref_lanes_4_7_i, ref_lanes_0_3_i};

  bsad_front #(
    .LANES    (LANES),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .cur_row_i    (cur_row),
    .ref_row_i    (ref_row),
    .block_rows_i (block_rows_q),
    .diff_o       (front_diff),
    .last_o       (front_last)
  );

  // ---------------------------------------------------------------------------
  // row queue between front and back: {last, lane differences}
  // ---------------------------------------------------------------------------
  assign row_q_wdata = {front_last, front_diff};

  bsad_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROW_Q_DEPTH)
  ) u_row_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (row_q_wdata),
    .full_o  (full),
    .pop_i   (row_q_pop),
    .rdata_o (row_q_rdata),
    .empty_o (row_q_empty),
    .count_o (row_q_count)
  );

  // ---------------------------------------------------------------------------
  // back: accumulate, reduce on the last row, queue the total
  // ---------------------------------------------------------------------------
  bsad_back #(
    .LANES (LANES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_valid_i (!row_q_empty),
    .row_diff_i  (row_q_rdata[ENTRY_W-2:0]),
    .row_last_i  (row_q_rdata[ENTRY_W-1]),
    .row_pop_o   (row_q_pop),
    .res_pop_i   (pop && !empty),
    .res_empty_o (empty),
    .res_total_o (sad_total_o)
  );

`ifndef SYNTH
  a_full_means_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (row_q_count != '0))
    else $error("row queue full flag without entries");
`endif

endmodule

// ===== bench/block_sad_int16_test.sv =====
// ----------------------------------------------------------------------------
// block_sad_int16_test
// self-checking bench for the block sad engine
// ----------------------------------------------------------------------------
// rows of current and reference samples go in through the push side, block
// totals come back on the pop side. every accepted row runs through a local
// model of the lane accumulators, and each total it produces waits in a queue
// until the block's total is popped. a short table of hand-picked rows comes
// first, then phases of random rows at several block heights, with random
// gaps on both sides, a long receiver stall and two stretches with no gaps
// ----------------------------------------------------------------------------
module block_sad_int16_test import bsad_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let the pipeline settle before touching the height register
  localparam int SETTLE_CYCLES = 12;
  // receiver stall long enough to fill the row and result queues
  localparam int HOLD_CYCLES   = 150;

  localparam logic [APB_ADDR_W-1:0] ADDR_ROWS   = {REG_BLOCK_ROWS, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  // corner sample values used by the random rows
  localparam logic [SAMPLE_W-1:0] CORNERS [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

  typedef struct packed {
    logic [3:0][FIELD_W-1:0] cur_w;
    logic [3:0][FIELD_W-1:0] ref_w;
  } row_t;

  typedef enum logic [0:0] {
    STEP_ROW,
    STEP_CFG
  } step_kind_e;

  typedef struct packed {
    step_kind_e                 kind;
    logic [APB_ADDR_W-1:0]      addr;
    logic [APB_DATA_W-1:0]      data;
    row_t                       row;
    logic                       typed;
    logic signed [TOTAL_W-1:0]  total;
  } step_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // row side
  logic push = 1'b0;
  logic full;
  row_t drive_row = '0;

  // result side
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [TOTAL_W-1:0] sad_total;

  // register port
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // pacing controls
  logic no_idle   = 1'b0;
  int   hold_left = 0;

  // model state: lane accumulators, rows taken, height register
  logic [SAMPLE_W-1:0]      lane_acc [ROW_SAMPLES];
  int unsigned              rows_taken = 0;
  logic [CFG_W-1:0]         rows_cfg   = ROWS_RESET;

  logic signed [TOTAL_W-1:0] total_q [$];
  logic signed [TOTAL_W-1:0] want_total;
  int                        errors = 0;
  step_t                     steps [$];

  block_sad_int16 dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .cur_lanes_0_3_i   (drive_row.cur_w[0]),
    .cur_lanes_4_7_i   (drive_row.cur_w[1]),
    .cur_lanes_8_11_i  (drive_row.cur_w[2]),
    .cur_lanes_12_15_i (drive_row.cur_w[3]),
    .ref_lanes_0_3_i   (drive_row.ref_w[0]),
    .ref_lanes_4_7_i   (drive_row.ref_w[1]),
    .ref_lanes_8_11_i  (drive_row.ref_w[2]),
    .ref_lanes_12_15_i (drive_row.ref_w[3]),
    .empty             (empty),
    .pop               (pop),
    .sad_total_o       (sad_total),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < ROW_SAMPLES; i++) lane_acc[i] = '0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    $display("mismatch at %0t: %s want %0d got %0d", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------- model ---

  // saturating difference, then 16-bit magnitude; -32768 stays 0x8000
  function automatic logic [SAMPLE_W-1:0] abs_sat_diff(input logic signed [SAMPLE_W-1:0] a,
                                                       input logic signed [SAMPLE_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    if (d < 0) d = -d;
    return d[SAMPLE_W-1:0];
  endfunction

  // takes one row into the lane sums; on a block's last row gives the total
  function automatic void sad_accumulate(input row_t r, output bit done,
                                         output logic signed [TOTAL_W-1:0] total);
    int          sum;
    int unsigned height;
    logic [SAMPLE_W-1:0] c, b;
    sum  = 0;
    done = 1'b0;
    total = '0;
    for (int lane = 0; lane < ROW_SAMPLES; lane++) begin
      if (lane < DEF_LANES) begin
        c = r.cur_w[lane/4][(lane%4)*SAMPLE_W +: SAMPLE_W];
        b = r.ref_w[lane/4][(lane%4)*SAMPLE_W +: SAMPLE_W];
        lane_acc[lane] = lane_acc[lane] + abs_sat_diff(c, b);
      end
    end
    rows_taken = rows_taken + 1;
    // a height of zero counts as one, anything above the maximum as the maximum
    height = rows_cfg;
    if (height < 1) height = 1;
    if (height > DEF_MAX_ROWS) height = DEF_MAX_ROWS;
    if (rows_taken >= height) begin
      for (int lane = 0; lane < ROW_SAMPLES; lane++) begin
        sum = sum + $signed(lane_acc[lane]);
        lane_acc[lane] = '0;
      end
      rows_taken = 0;
      total = sum[TOTAL_W-1:0];
      done  = 1'b1;
    end
  endfunction

  // ------------------------------------------------------------- stimulus ---

  function automatic row_t flat_row(input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] b);
    row_t r;
    r.cur_w = {16{c}};
    r.ref_w = {16{b}};
    return r;
  endfunction

  // each lane picks its own flavor: wide random, corners, near-equal, small
  function automatic row_t random_row();
    row_t r;
    logic [SAMPLE_W-1:0] c, b;
    for (int lane = 0; lane < ROW_SAMPLES; lane++) begin
      case ($urandom_range(0, 3))
        0: begin
          c = SAMPLE_W'($urandom);
          b = SAMPLE_W'($urandom);
        end
        1: begin
          c = CORNERS[$urandom_range(0, 3)];
          b = CORNERS[$urandom_range(0, 3)];
        end
        2: begin
          c = SAMPLE_W'($urandom);
          b = c + 16'($urandom_range(0, 16)) - 16'd8;
        end
        default: begin
          c = 16'($urandom_range(0, 511)) - 16'd256;
          b = 16'($urandom_range(0, 511)) - 16'd256;
        end
      endcase
      r.cur_w[lane/4][(lane%4)*SAMPLE_W +: SAMPLE_W] = c;
      r.ref_w[lane/4][(lane%4)*SAMPLE_W +: SAMPLE_W] = b;
    end
    return r;
  endfunction

  function automatic step_t row_step(input row_t r, input logic typed,
                                     input logic signed [TOTAL_W-1:0] total);
    step_t s;
    s = '0;
    s.kind  = STEP_ROW;
    s.row   = r;
    s.typed = typed;
    s.total = total;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [APB_ADDR_W-1:0] addr,
                                     input logic [APB_DATA_W-1:0] data);
    step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.addr = addr;
    s.data = data;
    return s;
  endfunction

  // one row transaction; push stays high into the next row unless a gap is drawn
  task automatic send_row(input row_t r, input logic typed,
                          input logic signed [TOTAL_W-1:0] typed_total);
    bit done;
    logic signed [TOTAL_W-1:0] total;
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    push      <= 1'b1;
    drive_row <= r;
    do @(posedge clk_i); while (full);
    sad_accumulate(r, done, total);
    if (done) total_q.push_back(typed ? typed_total : total);
  endtask

  // wait for every pending total, then let the pipeline empty out
  task automatic drain();
    push <= 1'b0;
    while (total_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup and access write, then read the height register back
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // only the height register exists, other indexes are dropped
    if (addr == ADDR_ROWS) rows_cfg = data[CFG_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel  <= 1'b1;
    paddr <= ADDR_ROWS;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DATA_W'(rows_cfg)) report_mismatch("block_rows readback", rows_cfg, rd);
  endtask

  // hand-picked opening rows; typed totals are the obvious ones
  function automatic void fill_table();
    row_t mix;
    // three rows into a block of the reset height, no total yet
    mix.cur_w = {64'h8000_7FFF_0001_FFFF, 64'h1234_EDCB_0000_7FFF,
                 64'hFFFF_8000_0100_FF00, 64'h0040_FFC0_7000_9000};
    mix.ref_w = {64'h7FFF_8000_FFFF_0001, 64'h1200_EDCB_8000_0000,
                 64'h0001_8001_00FF_FF01, 64'hFFC0_0040_9000_7000};
    steps.push_back(row_step(mix, 1'b0, '0));
    steps.push_back(row_step(flat_row(16'h0123, 16'hFEDC), 1'b0, '0));
    steps.push_back(row_step({mix.ref_w, mix.cur_w}, 1'b0, '0));
    // height lowered below the rows already taken: the next row ends the block
    steps.push_back(cfg_step(ADDR_ROWS, 32'd2));
    steps.push_back(row_step(mix, 1'b0, '0));
    // height one, upper data bits set and ignored
    steps.push_back(cfg_step(ADDR_ROWS, 32'hFFFF_FFE1));
    steps.push_back(row_step(flat_row(16'h0000, 16'h0000), 1'b1, 20'sd0));
    steps.push_back(row_step(flat_row(16'h7FFF, 16'h8000), 1'b1, 20'sd524272));
    steps.push_back(row_step(flat_row(16'h8000, 16'h7FFF), 1'b1, -20'sd524288));
    steps.push_back(row_step(flat_row(16'h0000, 16'h8000), 1'b1, 20'sd524272));
    steps.push_back(row_step(flat_row(16'hFFFF, 16'h0001), 1'b1, 20'sd32));
    steps.push_back(row_step(mix, 1'b0, '0));
    // height zero behaves as one
    steps.push_back(cfg_step(ADDR_ROWS, 32'd0));
    steps.push_back(row_step(flat_row(16'h8000, 16'h7FFF), 1'b1, -20'sd524288));
    steps.push_back(row_step({mix.ref_w, mix.cur_w}, 1'b0, '0));
    // write to an index with no register behind it
    steps.push_back(cfg_step(ADDR_UNUSED, 32'd5));
    steps.push_back(row_step(mix, 1'b0, '0));
    // two saturated rows wrap each lane to 0xFFFE, read back as -2
    steps.push_back(cfg_step(ADDR_ROWS, 32'd2));
    steps.push_back(row_step(flat_row(16'h7FFF, 16'h8000), 1'b0, '0));
    steps.push_back(row_step(flat_row(16'h7FFF, 16'h8000), 1'b1, -20'sd32));
    // height above the maximum, carried into the first random phase
    steps.push_back(cfg_step(ADDR_ROWS, 32'd31));
  endfunction

  // ------------------------------------------------------------- receiver ---

  // receiver stall counter, armed by the sender
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // compare each popped total with the oldest expectation, then draw pop
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (total_q.size() == 0) begin
          report_mismatch("total with nothing pending", 0, sad_total);
        end else begin
          want_total = total_q.pop_front();
          if (sad_total !== want_total) report_mismatch("sad_total", want_total, sad_total);
        end
      end
      if (hold_left != 0) pop <= 1'b0;
      else if (no_idle) pop <= 1'b1;
      else pop <= ($urandom_range(0, 99) >= 25);
    end
  end

  // --------------------------------------------------------------- sender ---

  initial begin
    int heights [12];
    int h;
    int n_rows;
    heights = '{31, 1, 0, 17, 5, 2, 16, 3, -1, -1, 16, -1};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    fill_table();
    foreach (steps[i]) begin
      if (steps[i].kind == STEP_CFG) begin
        drain();
        reg_write(steps[i].addr, steps[i].data);
      end else begin
        send_row(steps[i].row, steps[i].typed, steps[i].total);
      end
    end

    // random phases; a negative height means draw one
    for (int p = 0; p < 12; p++) begin
      if (p > 0) begin
        // a partial block left over here exercises the mid-block height change
        drain();
        h = (heights[p] < 0) ? $urandom_range(0, 31) : heights[p];
        reg_write(ADDR_ROWS, h);
      end
      if (p == 4) begin
        // one total per row while the receiver stalls: queues fill, full rises
        reg_write(ADDR_ROWS, 1);
        hold_left <= HOLD_CYCLES;
        no_idle   <= 1'b1;
        repeat (40) send_row(random_row(), 1'b0, '0);
        drain();
        no_idle <= 1'b0;
        reg_write(ADDR_ROWS, heights[p]);
      end
      if (p == 6) no_idle <= 1'b1;
      n_rows = 60 + $urandom_range(0, 9);
      repeat (n_rows) send_row(random_row(), 1'b0, '0);
      if (p == 6) no_idle <= 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
